[rtl/cdpp_pkg.sv]
// ----------------------------------------------------------------------------
// cdpp_pkg: shared types and constants of the caption data packet parser
// Holds the parser phase encoding, status codes, marker bytes and the event
// record that travels from the parser front end to the result back end.
// ----------------------------------------------------------------------------
package cdpp_pkg;

    // Largest length byte sum the length check accepts
    localparam logic [12:0] MAX_PACKET_LEN = 13'd4095;

    // Default depth of the event queue between front and back
    localparam int CDPP_QUEUE_DEPTH = 4;

    // Packet marker bytes
    localparam logic [7:0] ID_BYTE0       = 8'h96;
    localparam logic [7:0] ID_BYTE1       = 8'h69;
    localparam logic [7:0] SECTION_MARKER = 8'h72;
    localparam logic [7:0] END_MARKER_A   = 8'h73;
    localparam logic [7:0] END_MARKER_B   = 8'h74;
    localparam logic [7:0] PAD_HDR_A      = 8'hFA;
    localparam logic [7:0] PAD_HDR_B      = 8'hFC;
    localparam logic [7:0] PAD_HDR_C      = 8'hFD;
    localparam logic [3:0] MIN_PACKET_LEN = 4'd4;

    // Flag byte bits
    localparam int FLAG_DATA_BIT = 6;
    localparam int FLAG_TC_BIT   = 7;

    // Item kinds on the result channel
    localparam logic KIND_TRIPLET = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [3:0] {
        PH_ID0   = 4'd0,
        PH_ID1   = 4'd1,
        PH_LEN   = 4'd2,
        PH_RATE  = 4'd3,
        PH_FLAGS = 4'd4,
        PH_CNT0  = 4'd5,
        PH_CNT1  = 4'd6,
        PH_TC    = 4'd7,
        PH_SECT  = 4'd8,
        PH_COUNT = 4'd9,
        PH_TRIP  = 4'd10,
        PH_DONE  = 4'd11,
        PH_SKIP  = 4'd12
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_ID     = 3'd1,
        ST_LEN_MISMATCH = 3'd2,
        ST_NO_DATA    = 3'd3,
        ST_NO_SECTION = 3'd4,
        ST_BAD_COUNT  = 3'd5,
        ST_TOO_SHORT  = 3'd6,
        ST_EARLY_END  = 3'd7
    } status_t;

    // One queue entry: the results caused by one accepted byte
    typedef struct packed {
        logic       has_trip;
        logic       valid_bit;
        logic [1:0] triplet_type;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic       has_status;
        status_t    status;
    } event_t;

endpackage

[rtl/cdpp_front.sv]
// ----------------------------------------------------------------------------
// cdpp_front: packet byte parser
// Walks the packet header, timecode, section and triplet bytes one byte per
// transaction and produces at most one event (triplet and/or status) per byte.
// ----------------------------------------------------------------------------
module cdpp_front
    import cdpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  packet_byte,
    input  logic [11:0] packet_length,
    input  logic        last_byte,
    output logic        ev_push,
    output event_t      ev
);

    phase_t      phase_reg, phase_next;
    logic [11:0] remain_reg, remain_next;
    logic        tc_reg, tc_next;
    logic [4:0]  left_reg, left_next;
    logic [1:0]  slot_reg, slot_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [7:0]  data_reg, data_next;
    status_t     err_reg, err_next;

    logic [11:0] left_after;
    logic [12:0] len_sum;
    logic [4:0]  trip_cnt;
    logic [11:0] cc_room;
    logic        pad_trip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ID0;
            remain_reg <= '0;
            tc_reg     <= 1'b0;
            left_reg   <= '0;
            slot_reg   <= '0;
            hdr_reg    <= '0;
            data_reg   <= '0;
            err_reg    <= ST_OK;
        end
        else
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            tc_reg     <= tc_next;
            left_reg   <= left_next;
            slot_reg   <= slot_next;
            hdr_reg    <= hdr_next;
            data_reg   <= data_next;
            err_reg    <= err_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        tc_next     = tc_reg;
        left_next   = left_reg;
        slot_next   = slot_reg;
        hdr_next    = hdr_reg;
        data_next   = data_reg;
        err_next    = err_reg;
        ev          = '0;
        ev_push     = 1'b0;
        left_after  = '0;
        len_sum     = '0;
        trip_cnt    = packet_byte[4:0];
        cc_room     = 12'({trip_cnt, 1'b0}) + 12'(trip_cnt);
        pad_trip    = 1'b0;

        if (accept)
        begin
            // Sample the length on the first byte of a packet
            if (phase_reg == PH_ID0)
            begin
                remain_next = packet_length;
                if (packet_length < 12'(MIN_PACKET_LEN))
                begin
                    err_next   = ST_TOO_SHORT;
                    phase_next = PH_SKIP;
                end
            end

            if (phase_next != PH_DONE && phase_next != PH_SKIP)
            begin
                if (remain_next == '0)
                begin
                    err_next   = ST_TOO_SHORT;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    left_after = remain_next - 12'd1;
                    len_sum    = {1'b0, remain_next} + 13'd2;
                    case (phase_next)
                        PH_ID0:
                        begin
                            if (packet_byte != ID_BYTE0)
                            begin
                                err_next   = ST_BAD_ID;
                                phase_next = PH_SKIP;
                            end
                            else
                                phase_next = PH_ID1;
                        end
                        PH_ID1:
                        begin
                            if (packet_byte != ID_BYTE1)
                            begin
                                err_next   = ST_BAD_ID;
                                phase_next = PH_SKIP;
                            end
                            else
                                phase_next = PH_LEN;
                        end
                        PH_LEN:
                        begin
                            if (len_sum > MAX_PACKET_LEN ||
                                {5'd0, packet_byte} != len_sum)
                            begin
                                err_next   = ST_LEN_MISMATCH;
                                phase_next = PH_SKIP;
                            end
                            else
                                phase_next = PH_RATE;
                        end
                        PH_RATE:
                            phase_next = PH_FLAGS;
                        PH_FLAGS:
                        begin
                            if (!packet_byte[FLAG_DATA_BIT])
                            begin
                                err_next   = ST_NO_DATA;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                tc_next    = packet_byte[FLAG_TC_BIT];
                                phase_next = PH_CNT0;
                            end
                        end
                        PH_CNT0:
                            phase_next = PH_CNT1;
                        PH_CNT1:
                        begin
                            slot_next  = '0;
                            phase_next = tc_next ? PH_TC : PH_SECT;
                        end
                        PH_TC:
                        begin
                            // Skip four timecode bytes
                            if (slot_next == 2'd3)
                            begin
                                slot_next  = '0;
                                phase_next = PH_SECT;
                            end
                            else
                                slot_next = slot_next + 2'd1;
                        end
                        PH_SECT:
                        begin
                            if (packet_byte != SECTION_MARKER)
                            begin
                                err_next   = ST_NO_SECTION;
                                phase_next = PH_SKIP;
                            end
                            else
                                phase_next = PH_COUNT;
                        end
                        PH_COUNT:
                        begin
                            if (!(trip_cnt inside {5'd10, 5'd20, 5'd25, 5'd30}))
                            begin
                                err_next   = ST_BAD_COUNT;
                                phase_next = PH_SKIP;
                            end
                            else if (left_after < cc_room)
                            begin
                                err_next   = ST_TOO_SHORT;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                left_next  = trip_cnt;
                                slot_next  = '0;
                                phase_next = PH_TRIP;
                            end
                        end
                        PH_TRIP:
                        begin
                            if (slot_next == 2'd0)
                            begin
                                if (packet_byte inside {END_MARKER_A, END_MARKER_B})
                                begin
                                    err_next   = ST_EARLY_END;
                                    phase_next = PH_SKIP;
                                end
                                else
                                begin
                                    hdr_next  = packet_byte;
                                    slot_next = 2'd1;
                                end
                            end
                            else if (slot_next == 2'd1)
                            begin
                                data_next = packet_byte;
                                slot_next = 2'd2;
                            end
                            else
                            begin
                                // Drop padding triplets and types below 2
                                pad_trip = (hdr_next inside {PAD_HDR_A, PAD_HDR_B, PAD_HDR_C})
                                           && data_next[6:0] == 7'd0
                                           && packet_byte[6:0] == 7'd0;
                                if (!pad_trip && hdr_next[1])
                                begin
                                    ev.has_trip     = 1'b1;
                                    ev.valid_bit    = hdr_next[2];
                                    ev.triplet_type = hdr_next[1:0];
                                    ev.first_data   = data_next;
                                    ev.second_data  = packet_byte;
                                end
                                slot_next = '0;
                                if (left_next != '0)
                                    left_next = left_next - 5'd1;
                                if (left_next == '0)
                                    phase_next = PH_DONE;
                            end
                        end
                        default:
                        begin
                            err_next   = ST_TOO_SHORT;
                            phase_next = PH_SKIP;
                        end
                    endcase
                    remain_next = left_after;
                end
            end

            if (last_byte)
            begin
                ev.has_status = 1'b1;
                if (phase_next == PH_SKIP)
                    ev.status = err_next;
                else if (phase_next == PH_DONE)
                    ev.status = ST_OK;
                else
                    ev.status = ST_TOO_SHORT;
                // Clear for the next packet
                phase_next  = PH_ID0;
                remain_next = '0;
                tc_next     = 1'b0;
                left_next   = '0;
                slot_next   = '0;
                hdr_next    = '0;
                data_next   = '0;
                err_next    = ST_OK;
            end

            ev_push = ev.has_trip | ev.has_status;
        end
    end

endmodule

[rtl/cdpp_queue.sv]
// ----------------------------------------------------------------------------
// cdpp_queue: event queue between parser and result back end
// Small circular buffer; the head entry is always visible to the back end.
// ----------------------------------------------------------------------------
module cdpp_queue
    import cdpp_pkg::*;
#(
    parameter int DEPTH = CDPP_QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  event_t wr_data,
    input  logic   rd_en,
    output event_t rd_data,
    output logic   full,
    output logic   empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    event_t          store [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + CW'(1);
        else if (!wr_en && rd_en)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_ptr_reg] <= wr_data;
    end

endmodule

[rtl/cdpp_back.sv]
// ----------------------------------------------------------------------------
// cdpp_back: result back end
// Unpacks the head event into result items: the triplet first, then the
// status item when the same byte closed the packet.
// ----------------------------------------------------------------------------
module cdpp_back
    import cdpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  event_t      head,
    input  logic        head_empty,
    input  logic        pop,
    output logic        head_pop,
    output logic        item_kind,
    output logic        valid_bit,
    output logic [1:0]  triplet_type,
    output logic [7:0]  first_data,
    output logic [7:0]  second_data,
    output logic [2:0]  parse_status
);

    logic sub_reg, sub_next;
    logic show_trip;
    logic take;

    assign show_trip = head.has_trip && !sub_reg;
    assign take      = pop && !head_empty;

    always_comb
    begin
        sub_next = sub_reg;
        head_pop = 1'b0;
        if (take)
        begin
            // Hold the entry when its status item still follows the triplet
            if (show_trip && head.has_status)
                sub_next = 1'b1;
            else
            begin
                sub_next = 1'b0;
                head_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sub_reg <= 1'b0;
        else
            sub_reg <= sub_next;
    end

    always_comb
    begin
        if (show_trip)
        begin
            item_kind    = KIND_TRIPLET;
            valid_bit    = head.valid_bit;
            triplet_type = head.triplet_type;
            first_data   = head.first_data;
            second_data  = head.second_data;
            parse_status = ST_OK;
        end
        else
        begin
            item_kind    = KIND_STATUS;
            valid_bit    = 1'b0;
            triplet_type = '0;
            first_data   = '0;
            second_data  = '0;
            parse_status = head.status;
        end
    end

endmodule

[rtl/caption_data_packet_parser_core.sv]
// ----------------------------------------------------------------------------
// caption_data_packet_parser_core: caption data packet parser
// Checks caption data packets byte by byte and emits caption triplets and a
// status item at the end of every packet.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive packet_byte, packet_length and
//   last_byte and raise push; a transaction completes on a clock edge with
//   push high and full low. One byte per cycle is accepted while full is low.
//   Result side is a queue read port: while empty is low the oldest result
//   item sits on item_kind..parse_status; raise pop to take it.
//   Results of a byte are written into the event queue by its transaction
//   and show once older items have been taken. The parser front end is a
//   state machine; a byte that yields both a triplet and the end status
//   occupies one queue entry and two result transactions.
//   When pop is held low the event queue (QUEUE_DEPTH entries) fills, then
//   full rises and input is held off until the receiver drains it; no item is
//   lost. Reset (rst_n low, asynchronous) empties the queue and returns the
//   parser to the packet identifier.
// ----------------------------------------------------------------------------
module caption_data_packet_parser_core
    import cdpp_pkg::*;
#(
    parameter int QUEUE_DEPTH = CDPP_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Byte input channel
    input  logic        push,
    output logic        full,
    input  logic [7:0]  packet_byte,
    input  logic [11:0] packet_length,
    input  logic        last_byte,
    // Result channel
    output logic        empty,
    input  logic        pop,
    output logic        item_kind,
    output logic        valid_bit,
    output logic [1:0]  triplet_type,
    output logic [7:0]  first_data,
    output logic [7:0]  second_data,
    output logic [2:0]  parse_status
);

    logic   accept;
    logic   ev_push;
    event_t ev;
    event_t head;
    logic   head_pop;

    // Accept a byte whenever the event queue has room
    assign accept = push && !full;

    cdpp_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .packet_byte   (packet_byte),
        .packet_length (packet_length),
        .last_byte     (last_byte),
        .ev_push       (ev_push),
        .ev            (ev)
    );

    cdpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ev_push),
        .wr_data (ev),
        .rd_en   (head_pop),
        .rd_data (head),
        .full    (full),
        .empty   (empty)
    );

    cdpp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_empty   (empty),
        .pop          (pop),
        .head_pop     (head_pop),
        .item_kind    (item_kind),
        .valid_bit    (valid_bit),
        .triplet_type (triplet_type),
        .first_data   (first_data),
        .second_data  (second_data),
        .parse_status (parse_status)
    );

endmodule
